### sv/mts_pkg.sv
// shared types, constants and the note frequency table of the melody tone sequencer
`timescale 1ns / 1ps
package mts_pkg;

  localparam int SONG_DEPTH_DEF = 256;

  localparam int REQ_W    = 3;
  localparam int FREQ_W   = 16;
  localparam int IDX_W    = 8;
  localparam int NOTE_W   = 5;
  localparam int LEN_W    = 3;
  localparam int RATE_W   = 20;
  localparam int WHOLE_W  = 16;
  localparam int SLEN_W   = 9;
  localparam int TICK_W   = 16;
  localparam int PERIOD_W = 20;
  localparam int CMP_W    = 19;
  localparam int MODE_W   = 2;
  localparam int POS_W    = 8;
  localparam int DIVD_W   = RATE_W + 1;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;
  localparam int IN_DW    = 32;
  localparam int OUT_DW   = 56;

  localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PLAY  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PAUSE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TONE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SONG = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TONE = 2'd2;

  localparam logic [1:0] REG_BASE_RATE = 2'd0;
  localparam logic [1:0] REG_WHOLE     = 2'd1;
  localparam logic [1:0] REG_SONG_LEN  = 2'd2;

  localparam logic [RATE_W-1:0]  BASE_RATE_RST = 20'd100000;
  localparam logic [WHOLE_W-1:0] WHOLE_RST     = 16'd1600;
  localparam logic [SLEN_W-1:0]  SONG_LEN_RST  = 9'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_NOTE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic {
    SRC_TONE,
    SRC_ROM
  } div_src_t;

  typedef struct packed {
    logic     capture;
    logic     exec;
    logic     note;
    logic     div_start;
    div_src_t div_src;
    logic     div_commit;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             song_mode;
    logic             note_due;
    logic             freq_zero;
    logic             note_silent;
    logic             div_done;
    logic             out_free;
  } sts_t;

  function automatic logic [FREQ_W-1:0] note_freq(input logic [NOTE_W-1:0] code);
    logic [FREQ_W-1:0] f;
    case (code)
      5'd1:    f = 16'd262;
      5'd2:    f = 16'd277;
      5'd3:    f = 16'd294;
      5'd4:    f = 16'd311;
      5'd5:    f = 16'd330;
      5'd6:    f = 16'd349;
      5'd7:    f = 16'd370;
      5'd8:    f = 16'd392;
      5'd9:    f = 16'd415;
      5'd10:   f = 16'd440;
      5'd11:   f = 16'd466;
      5'd12:   f = 16'd494;
      5'd13:   f = 16'd523;
      5'd14:   f = 16'd554;
      5'd15:   f = 16'd587;
      5'd16:   f = 16'd622;
      5'd17:   f = 16'd659;
      5'd18:   f = 16'd698;
      5'd19:   f = 16'd740;
      5'd20:   f = 16'd784;
      5'd21:   f = 16'd831;
      5'd22:   f = 16'd880;
      5'd23:   f = 16'd932;
      5'd24:   f = 16'd988;
      default: f = 16'd0;
    endcase
    return f;
  endfunction

  function automatic logic is_silent_note(input logic [NOTE_W-1:0] code);
    return !(code inside {[5'd1:5'd24]});
  endfunction

endpackage

### sv/melody_tone_sequencer.sv
// top level: register port, controller and datapath of the melody tone sequencer
// play, pause, load, plain ticks and zero tone pass from idle through the execute and output states;
// a tick that starts a rest note adds the note state; a tone request, and a tick that
// starts a sounding note, also wait in the divide state for the bit-serial period divider
// throughput: one request in work at a time, the next one taken the cycle after its result
// a finished result waits in the output register while the next request is taken
// synchronous active-low reset clears control and sequencer state, not the song memory
`timescale 1ns / 1ps
module melody_tone_sequencer #(
  parameter int SONG_DEPTH = mts_pkg::SONG_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // tone_freq[15:0], entry_index[23:16], entry_note[28:24], entry_length[31:29]
  input  logic [mts_pkg::IN_DW-1:0]   in_tdata,
  // req_type[2:0]
  input  logic [mts_pkg::REQ_W-1:0]   in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // pwm_period[19:0], pwm_compare[38:20], pwm_running[39], play_mode[41:40],
  // song_position[49:42], zero fill[55:50]
  output logic [mts_pkg::OUT_DW-1:0]  out_tdata,
  // period_update[0]
  output logic [0:0]                  out_tuser,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mts_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [mts_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [mts_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import mts_pkg::*;

  logic [RATE_W-1:0]  base_rate_r, base_rate_nxt;
  logic [WHOLE_W-1:0] whole_r, whole_nxt;
  logic [SLEN_W-1:0]  slen_r, slen_nxt;
  logic               cfg_wr;
  logic [1:0]         cfg_sel;
  cmd_t               cmd;
  sts_t               sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = cfg_paddr[3:2];

  always_comb begin
    base_rate_nxt = base_rate_r;
    whole_nxt     = whole_r;
    slen_nxt      = slen_r;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_BASE_RATE: base_rate_nxt = cfg_pwdata[RATE_W-1:0];
        REG_WHOLE:     whole_nxt     = cfg_pwdata[WHOLE_W-1:0];
        REG_SONG_LEN:  slen_nxt      = cfg_pwdata[SLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_BASE_RATE: cfg_prdata = CFG_DW'(base_rate_r);
      REG_WHOLE:     cfg_prdata = CFG_DW'(whole_r);
      REG_SONG_LEN:  cfg_prdata = CFG_DW'(slen_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_rate_r <= BASE_RATE_RST;
      whole_r     <= WHOLE_RST;
      slen_r      <= SONG_LEN_RST;
    end else begin
      base_rate_r <= base_rate_nxt;
      whole_r     <= whole_nxt;
      slen_r      <= slen_nxt;
    end
  end

  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mts_datapath #(
    .SONG_DEPTH(SONG_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .base_rate       (base_rate_r),
    .whole_note_ticks(whole_r),
    .song_length     (slen_r)
  );

endmodule

### sv/mts_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module mts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/mts_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module mts_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mts_pkg::DIVD_W-1:0] dividend,
  input  logic [mts_pkg::FREQ_W-1:0] divisor,
  output logic                      busy,
  output logic [mts_pkg::DIVD_W-1:0] quotient
);
  import mts_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] q_r, q_nxt;
  logic [FREQ_W-1:0] rem_r, rem_nxt;
  logic [FREQ_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [FREQ_W:0]   trial;
  logic [FREQ_W:0]   diff;

  always_comb begin
    trial    = {rem_r, q_r[DIVD_W-1]};
    diff     = trial - {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[FREQ_W-1:0];
        q_nxt   = {q_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[FREQ_W-1:0];
        q_nxt   = {q_r[DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

### sv/mts_datapath.sv
// sequencer state, song memory, period divider and output register
`timescale 1ns / 1ps
module mts_datapath #(
  parameter int SONG_DEPTH = mts_pkg::SONG_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mts_pkg::cmd_t               cmd,
  output mts_pkg::sts_t               sts,
  input  logic [mts_pkg::IN_DW-1:0]   in_tdata,
  input  logic [mts_pkg::REQ_W-1:0]   in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mts_pkg::OUT_DW-1:0]  out_tdata,
  output logic [0:0]                  out_tuser,
  input  logic [mts_pkg::RATE_W-1:0]  base_rate,
  input  logic [mts_pkg::WHOLE_W-1:0] whole_note_ticks,
  input  logic [mts_pkg::SLEN_W-1:0]  song_length
);
  import mts_pkg::*;

  localparam int AW = $clog2(SONG_DEPTH);
  localparam int CW = (AW + 1 > SLEN_W) ? AW + 1 : SLEN_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(SONG_DEPTH);

  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [FREQ_W-1:0]   freq_r, freq_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [NOTE_W-1:0]   enote_r, enote_nxt;
  logic [LEN_W-1:0]    elen_r, elen_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [TICK_W-1:0]   nticks_r, nticks_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [CMP_W-1:0]    cmp_r, cmp_nxt;
  logic                run_r, run_nxt;
  logic                upd_r, upd_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0]   out_data_r, out_data_nxt;
  logic                out_user_r, out_user_nxt;

  logic [NOTE_W+LEN_W-1:0] rd_data;
  logic [NOTE_W-1:0]       rd_note;
  logic [LEN_W-1:0]        rd_len;
  logic                    ram_we;
  logic [CW-1:0]           idx_ext;
  logic [CW-1:0]           pos_ext;
  logic [CW-1:0]           pos_inc;
  logic [CW-1:0]           slen_ext;
  logic [CW-1:0]           eff_len;
  logic [FREQ_W-1:0]       div_divisor;
  logic [DIVD_W-1:0]       div_dividend;
  logic                    div_busy;
  logic [DIVD_W-1:0]       div_quot;

  assign rd_note  = rd_data[NOTE_W+LEN_W-1:LEN_W];
  assign rd_len   = rd_data[LEN_W-1:0];
  assign idx_ext  = {{(CW-IDX_W){1'b0}}, idx_r};
  assign pos_ext  = {{(CW-AW){1'b0}}, pos_r};
  assign pos_inc  = pos_ext + CW'(1);
  assign slen_ext = {{(CW-SLEN_W){1'b0}}, song_length};

  always_comb begin
    if (slen_ext == '0) begin
      eff_len = CW'(1);
    end else if (slen_ext > DEPTH_C) begin
      eff_len = DEPTH_C;
    end else begin
      eff_len = slen_ext;
    end
  end

  mts_ram #(
    .WIDTH(NOTE_W + LEN_W),
    .DEPTH(SONG_DEPTH)
  ) u_song_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_ext[AW-1:0]),
    .wdata({enote_r, elen_r}),
    .raddr(pos_r),
    .rdata(rd_data)
  );

  assign div_divisor  = (cmd.div_src == SRC_TONE) ? freq_r : note_freq(rd_note);
  assign div_dividend = {1'b0, base_rate} + DIVD_W'(div_divisor[FREQ_W-1:1]);

  mts_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .busy    (div_busy),
    .quotient(div_quot)
  );

  always_comb begin
    req_nxt       = req_r;
    freq_nxt      = freq_r;
    idx_nxt       = idx_r;
    enote_nxt     = enote_r;
    elen_nxt      = elen_r;
    mode_nxt      = mode_r;
    tick_nxt      = tick_r;
    nticks_nxt    = nticks_r;
    pos_nxt       = pos_r;
    period_nxt    = period_r;
    cmp_nxt       = cmp_r;
    run_nxt       = run_r;
    upd_nxt       = upd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    ram_we        = 1'b0;

    if (cmd.capture) begin
      req_nxt   = in_tuser;
      freq_nxt  = in_tdata[15:0];
      idx_nxt   = in_tdata[23:16];
      enote_nxt = in_tdata[28:24];
      elen_nxt  = in_tdata[31:29];
      upd_nxt   = 1'b0;
    end

    if (cmd.exec) begin
      case (req_r)
        REQ_TICK: begin
          if (mode_r == MODE_SONG) begin
            tick_nxt = tick_r + TICK_W'(1);
          end
        end
        REQ_PLAY: begin
          mode_nxt = MODE_SONG;
          run_nxt  = 1'b1;
        end
        REQ_PAUSE: begin
          mode_nxt = MODE_OFF;
          run_nxt  = 1'b0;
        end
        REQ_TONE: begin
          mode_nxt = MODE_TONE;
          run_nxt  = 1'b1;
          upd_nxt  = 1'b1;
          if (freq_r == '0) begin
            period_nxt = '0;
            cmp_nxt    = '0;
          end
        end
        REQ_LOAD: begin
          ram_we = (idx_ext < DEPTH_C);
        end
        default: begin
        end
      endcase
    end

    if (cmd.note) begin
      upd_nxt    = 1'b1;
      nticks_nxt = whole_note_ticks >> rd_len;
      tick_nxt   = TICK_W'(1);
      if (is_silent_note(rd_note)) begin
        cmp_nxt = '0;
      end
      if (pos_inc >= eff_len) begin
        pos_nxt  = '0;
        run_nxt  = 1'b0;
        mode_nxt = MODE_OFF;
      end else begin
        pos_nxt = pos_inc[AW-1:0];
      end
    end

    if (cmd.div_commit) begin
      period_nxt = div_quot[PERIOD_W-1:0];
      cmp_nxt    = div_quot[PERIOD_W-1:1];
      upd_nxt    = 1'b1;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {6'b0, pos_ext[POS_W-1:0], mode_r, run_r, cmp_r, period_r};
      out_user_nxt  = upd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_OFF;
      tick_r      <= '0;
      nticks_r    <= '0;
      pos_r       <= '0;
      period_r    <= '0;
      cmp_r       <= '0;
      run_r       <= 1'b0;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      tick_r      <= tick_nxt;
      nticks_r    <= nticks_nxt;
      pos_r       <= pos_nxt;
      period_r    <= period_nxt;
      cmp_r       <= cmp_nxt;
      run_r       <= run_nxt;
      upd_r       <= upd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    freq_r     <= freq_nxt;
    idx_r      <= idx_nxt;
    enote_r    <= enote_nxt;
    elen_r     <= elen_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign sts.req         = req_r;
  assign sts.song_mode   = (mode_r == MODE_SONG);
  assign sts.note_due    = (tick_r >= nticks_r);
  assign sts.freq_zero   = (freq_r == '0);
  assign sts.note_silent = is_silent_note(rd_note);
  assign sts.div_done    = !div_busy;
  assign sts.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### sv/mts_ctrl.sv
// request sequencing state machine
`timescale 1ns / 1ps
module mts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  mts_pkg::sts_t sts,
  output mts_pkg::cmd_t cmd
);
  import mts_pkg::*;

  state_t state_r, state_nxt;
  logic   note_start;

  assign note_start = (sts.req == REQ_TICK) && sts.song_mode && sts.note_due;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (note_start) begin
          state_nxt = ST_NOTE;
        end else if (sts.req == REQ_TONE && !sts.freq_zero) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_NOTE: begin
        state_nxt = sts.note_silent ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_EXEC: begin
        if (!note_start) begin
          cmd.exec = 1'b1;
          if (sts.req == REQ_TONE && !sts.freq_zero) begin
            cmd.div_start = 1'b1;
            cmd.div_src   = SRC_TONE;
          end
        end
      end
      ST_NOTE: begin
        cmd.note = 1'b1;
        if (!sts.note_silent) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = SRC_ROM;
        end
      end
      ST_DIV: begin
        cmd.div_commit = sts.div_done;
      end
      ST_OUT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/mts_checker.sv
// port-level checks of the melody tone sequencer and their binding
`timescale 1ns / 1ps
module mts_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [mts_pkg::OUT_DW-1:0] out_tdata,
  input logic [0:0]                 out_tuser
);
  import mts_pkg::*;

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // one request in work at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in work");

  // timer runs exactly when a song or a tone plays
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[41:40] == MODE_OFF) == !out_tdata[39]))
    else $error("running flag disagrees with mode");

  // compare never exceeds half the period
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[38:20] <= out_tdata[19:1]))
    else $error("compare above half period");

endmodule

bind melody_tone_sequencer mts_checker u_mts_checker (.*);
